// File: rtl/core/jse_pkg.sv
// Shared types and constants of the JSON string escaper.
package jse_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;

   // Work for one accepted item: single-byte units of a broken sequence, one
   // main unit (escape, plain byte or complete UTF-8 sequence), single-byte
   // units flushed at string end, then the optional end report.
   typedef struct packed {
      logic            first;
      logic            report;
      logic [1:0]      pre_count;
      logic [2:0][7:0] pre_bytes;
      logic [2:0]      mid_len;
      logic [5:0][7:0] mid_bytes;
      logic [1:0]      suf_count;
      logic [2:0][7:0] suf_bytes;
   } cmd_type;

endpackage

// File: rtl/core/json_string_escaper_utf8_budget.sv
// Top level of the JSON string escaper with UTF-8 grouping and byte budget.
//
// One input beat carries one source byte of a string. The front end accepts a
// beat every cycle while its two-entry command queue has room and turns it into
// output units; the back end sends one output beat per cycle while the receiver
// takes each beat. An item causes zero to ten output beats. The unit that first
// exceeds the budget takes a back-end step with no beat, and so does the last
// step of an item that has work queued but sends no beat there (it only opens a
// string, its units are skipped after a budget stop, or its units are cut off and
// it closes no string). An empty middle item queues nothing and never reaches the
// back end. The back end sets the sustained rate. The first result of an item
// passes through the queue entry, written at the accepting edge, and then the
// output register, and it may wait there behind earlier items.
module json_string_escaper_utf8_budget
   import jse_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_first_of_string,
   input  logic                    req_last_of_string,
   input  logic                    req_string_empty,
   input  logic [OFFSET_WIDTH-1:0] req_start_offset,
   input  logic [OFFSET_WIDTH-1:0] req_capacity,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic [OFFSET_WIDTH-1:0] rsp_write_offset,
   output logic                    rsp_carries_byte,
   output logic                    rsp_end_of_run,
   output logic                    rsp_string_done,
   output logic [OFFSET_WIDTH-1:0] rsp_final_offset
);

   localparam int CMD_BITS = $bits(cmd_type);
   localparam int QW       = CMD_BITS + 2 * OFFSET_WIDTH;

   cmd_type                 front_cmd, head_cmd;
   logic                    cmd_push, queue_full, head_valid, head_pop;
   logic [QW-1:0]           push_data, pop_data;
   logic [OFFSET_WIDTH-1:0] head_start, head_cap;

   assign push_data  = {front_cmd, req_start_offset, req_capacity};
   assign head_cmd   = cmd_type'(pop_data[QW-1 -: CMD_BITS]);
   assign head_start = pop_data[2*OFFSET_WIDTH-1 -: OFFSET_WIDTH];
   assign head_cap   = pop_data[OFFSET_WIDTH-1:0];

   jse_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .req_string_empty    (req_string_empty),
      .queue_full          (queue_full),
      .cmd_push            (cmd_push),
      .cmd                 (front_cmd)
   );

   jse_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (head_pop),
      .pop_data  (pop_data),
      .not_empty (head_valid)
   );

   jse_back #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .head_start       (head_start),
      .head_cap         (head_cap),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_write_offset (rsp_write_offset),
      .rsp_carries_byte (rsp_carries_byte),
      .rsp_end_of_run   (rsp_end_of_run),
      .rsp_string_done  (rsp_string_done),
      .rsp_final_offset (rsp_final_offset)
   );

endmodule

// File: rtl/core/jse_front.sv
// Front end: UTF-8 hold state and classification of each byte into units.
module jse_front
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   input  logic       req_string_empty,
   input  logic       queue_full,
   output logic       cmd_push,
   output cmd_type    cmd
);

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0c;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CTRL_LIMIT     = 8'h20;
   localparam logic [7:0] LEAD2_LO       = 8'hc2;
   localparam logic [7:0] LEAD2_HI       = 8'hdf;
   localparam logic [7:0] LEAD3_LO       = 8'he0;
   localparam logic [7:0] LEAD3_HI       = 8'hef;
   localparam logic [7:0] LEAD4_LO       = 8'hf0;
   localparam logic [7:0] LEAD4_HI       = 8'hf4;
   localparam logic [1:0] CONT_TAG       = 2'b10;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CHAR_ZERO + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

   logic [2:0][7:0] held_ff, held_in, held_e;
   logic [1:0]      count_ff, count_in, count_e;
   logic [2:0]      want_ff, want_in, want_e;
   logic            accept;
   logic            do_fresh;
   logic [2:0]      lead_len;
   logic [7:0]      c;

   assign c         = req_text_byte;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cmd_push  = accept && (req_first_of_string || req_last_of_string ||
                                 cmd.pre_count != 2'd0 || cmd.mid_len != 3'd0);

   always_comb begin
      if (c >= LEAD2_LO && c <= LEAD2_HI) begin
         lead_len = 3'd2;
      end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
         lead_len = 3'd3;
      end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd1;
      end
   end

   always_comb begin
      held_e  = req_first_of_string ? '0 : held_ff;
      count_e = req_first_of_string ? 2'd0 : count_ff;
      want_e  = req_first_of_string ? 3'd0 : want_ff;
      held_in  = held_e;
      count_in = count_e;
      want_in  = want_e;
      cmd        = '0;
      cmd.first  = req_first_of_string;
      cmd.report = req_last_of_string;
      do_fresh   = 1'b0;
      if (!req_string_empty) begin
         if (count_e == 2'd0) begin
            do_fresh = 1'b1;
         end else if (c[7:6] != CONT_TAG) begin
            cmd.pre_count = count_e;
            cmd.pre_bytes = held_e;
            count_in = 2'd0;
            want_in  = 3'd0;
            do_fresh = 1'b1;
         end else if ({1'b0, count_e} + 3'd1 >= want_e || count_e == 2'd3) begin
            for (int i = 0; i < 3; i++) begin
               if (i < count_e) begin
                  cmd.mid_bytes[i] = held_e[i];
               end
            end
            case (count_e)
               2'd1: cmd.mid_bytes[1] = c;
               2'd2: cmd.mid_bytes[2] = c;
               2'd3: cmd.mid_bytes[3] = c;
               default: cmd.mid_bytes[0] = c;
            endcase
            cmd.mid_len = {1'b0, count_e} + 3'd1;
            count_in = 2'd0;
            want_in  = 3'd0;
         end else begin
            held_in[count_e] = c;
            count_in = count_e + 2'd1;
         end
      end
      if (do_fresh) begin
         if (lead_len > 3'd1) begin
            held_in[0] = c;
            count_in   = 2'd1;
            want_in    = lead_len;
         end else begin
            cmd.mid_bytes[0] = CHAR_BACKSLASH;
            cmd.mid_len      = 3'd2;
            case (c)
               CHAR_QUOTE:     cmd.mid_bytes[1] = CHAR_QUOTE;
               CHAR_BACKSLASH: cmd.mid_bytes[1] = CHAR_BACKSLASH;
               CHAR_LF:        cmd.mid_bytes[1] = CHAR_N;
               CHAR_CR:        cmd.mid_bytes[1] = CHAR_R;
               CHAR_TAB:       cmd.mid_bytes[1] = CHAR_T;
               CHAR_BS:        cmd.mid_bytes[1] = CHAR_B;
               CHAR_FF:        cmd.mid_bytes[1] = CHAR_F;
               default: begin
                  if (c < CTRL_LIMIT) begin
                     cmd.mid_bytes[1] = CHAR_U;
                     cmd.mid_bytes[2] = CHAR_ZERO;
                     cmd.mid_bytes[3] = CHAR_ZERO;
                     cmd.mid_bytes[4] = hex_digit(c[7:4]);
                     cmd.mid_bytes[5] = hex_digit(c[3:0]);
                     cmd.mid_len      = 3'd6;
                  end else begin
                     cmd.mid_bytes[0] = c;
                     cmd.mid_len      = 3'd1;
                  end
               end
            endcase
         end
      end
      if (req_last_of_string) begin
         cmd.suf_count = count_in;
         cmd.suf_bytes = held_in;
         count_in = 2'd0;
         want_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         want_ff  <= 3'd0;
      end else if (accept) begin
         count_ff <= count_in;
         want_ff  <= want_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// File: rtl/core/jse_queue.sv
// Short FIFO of unit commands between front and back.
module jse_queue
   import jse_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/jse_back.sv
// Back end: budget check, offset tracking and output beats with register.
module jse_back
   import jse_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  cmd_type                 head_cmd,
   input  logic [OFFSET_WIDTH-1:0] head_start,
   input  logic [OFFSET_WIDTH-1:0] head_cap,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic [OFFSET_WIDTH-1:0] rsp_write_offset,
   output logic                    rsp_carries_byte,
   output logic                    rsp_end_of_run,
   output logic                    rsp_string_done,
   output logic [OFFSET_WIDTH-1:0] rsp_final_offset
);

   localparam int         SW        = OFFSET_WIDTH + 2;
   localparam logic [2:0] SLOT_MID  = 3'd3;
   localparam logic [2:0] SLOT_SUF  = 3'd4;
   localparam logic [2:0] SLOT_NONE = 3'd7;

   function automatic logic [2:0] next_slot(input logic [6:0] mask, input logic [3:0] from);
      logic [2:0] r;
      r = SLOT_NONE;
      for (int i = 6; i >= 0; i--) begin
         if (mask[i] && i >= from) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   logic [OFFSET_WIDTH-1:0] off_ff, off_in, off_e, lim_ff, lim_e;
   logic                    stop_ff, stop_in, stop_e;
   logic                    fresh_ff;
   logic [2:0]              ptr_ff, ptr_in, ptr_e, idx_ff, idx_in, idx_e;
   logic [6:0]              vmask;
   logic                    load, active, fit, nfit, last_byte, out_free;
   logic [2:0]              ulen, nlen, nxt;
   logic [7:0]              ubyte;
   logic                    advance, pop_cond, emit, beat_report, beat_end;

   logic                    valid_ff;
   logic [7:0]              byte_ff;
   logic [OFFSET_WIDTH-1:0] woff_ff, fin_ff;
   logic                    carries_ff, end_ff, done_ff;

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_write_offset = woff_ff;
   assign rsp_carries_byte = carries_ff;
   assign rsp_end_of_run   = end_ff;
   assign rsp_string_done  = done_ff;
   assign rsp_final_offset = fin_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vmask[i]     = i < head_cmd.pre_count;
         vmask[i + 4] = i < head_cmd.suf_count;
      end
      vmask[3] = head_cmd.mid_len != 3'd0;
   end

   assign load   = head_cmd.first && fresh_ff;
   assign off_e  = load ? head_start : off_ff;
   assign lim_e  = load ? head_cap : lim_ff;
   assign stop_e = load ? 1'b0 : stop_ff;
   assign ptr_e  = fresh_ff ? next_slot(vmask, 4'd0) : ptr_ff;
   assign idx_e  = fresh_ff ? 3'd0 : idx_ff;
   assign active = ptr_e != SLOT_NONE && !stop_e;
   assign nxt    = next_slot(vmask, {1'b0, ptr_e} + 4'd1);
   assign ulen   = (ptr_e == SLOT_MID) ? head_cmd.mid_len : 3'd1;
   assign nlen   = (nxt == SLOT_MID) ? head_cmd.mid_len : 3'd1;
   assign fit    = SW'(off_e) + SW'(ulen) <= SW'(lim_e);
   assign nfit   = SW'(off_e) + SW'(1) + SW'(nlen) <= SW'(lim_e);
   assign last_byte = idx_e == ulen - 3'd1;

   always_comb begin
      case (ptr_e)
         3'd0, 3'd1, 3'd2: ubyte = head_cmd.pre_bytes[ptr_e[1:0]];
         SLOT_MID:         ubyte = head_cmd.mid_bytes[idx_e];
         3'd4, 3'd5, 3'd6: ubyte = head_cmd.suf_bytes[2'(ptr_e - SLOT_SUF)];
         default:          ubyte = 8'd0;
      endcase
   end

   always_comb begin
      off_in      = off_e;
      stop_in     = stop_e;
      ptr_in      = ptr_e;
      idx_in      = idx_e;
      advance     = 1'b0;
      pop_cond    = 1'b0;
      emit        = 1'b0;
      beat_report = 1'b0;
      beat_end    = 1'b0;
      if (head_valid) begin
         if (active && idx_e == 3'd0 && !fit) begin
            stop_in = 1'b1;
            advance = 1'b1;
         end else if (active) begin
            emit    = 1'b1;
            advance = out_free;
            off_in  = off_e + OFFSET_WIDTH'(1);
            if (last_byte) begin
               ptr_in   = nxt;
               idx_in   = 3'd0;
               pop_cond = nxt == SLOT_NONE && !head_cmd.report;
               beat_end = !head_cmd.report && !(nxt != SLOT_NONE && nfit);
            end else begin
               idx_in = idx_e + 3'd1;
            end
         end else if (head_cmd.report) begin
            emit        = 1'b1;
            beat_report = 1'b1;
            beat_end    = 1'b1;
            advance     = out_free;
            pop_cond    = 1'b1;
         end else begin
            advance  = 1'b1;
            pop_cond = 1'b1;
         end
      end
   end

   assign head_pop = advance && pop_cond;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         lim_ff   <= '0;
         stop_ff  <= 1'b0;
         fresh_ff <= 1'b1;
         ptr_ff   <= SLOT_NONE;
         idx_ff   <= 3'd0;
      end else if (advance) begin
         off_ff   <= off_in;
         lim_ff   <= lim_e;
         stop_ff  <= stop_in;
         fresh_ff <= pop_cond;
         ptr_ff   <= ptr_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit && out_free) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         byte_ff    <= beat_report ? 8'd0 : ubyte;
         woff_ff    <= off_e;
         carries_ff <= !beat_report;
         end_ff     <= beat_end;
         done_ff    <= beat_report;
         fin_ff     <= beat_report ? off_e : '0;
      end
   end

endmodule

// File: verif/tb.sv
// Testbench for the JSON string escaper: random and directed strings, scoreboard check.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jse_pkg::*;

   localparam int          OW       = OFFSET_WIDTH_DEFAULT;
   localparam int unsigned OFF_MASK = (32'd1 << OW) - 1;
   localparam int          DRAIN    = 40;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // every escape, control extremes, DEL, 0xff and an overlong lead
   localparam logic [11:0][7:0] ESC_SET = {8'hc0, 8'hff, 8'h7f, 8'h1f, 8'h00, 8'h0c,
                                           8'h08, 8'h09, 8'h0d, 8'h0a, 8'h5c, 8'h22};
   // 3- and 4-byte sequences, a broken 2-byte lead, a lead held at string end
   localparam logic [9:0][7:0] UTF_SET = {8'he0, 8'h41, 8'hc3, 8'h80, 8'h98,
                                          8'h9f, 8'hf0, 8'hac, 8'h82, 8'he2};

   typedef struct {
      logic [7:0]    text;
      bit            first;
      bit            last;
      bit            empty;
      logic [OW-1:0] start;
      logic [OW-1:0] cap;
      bit            hold;
   } src_item_type;

   typedef struct {
      logic [7:0]    out_byte;
      logic [OW-1:0] write_offset;
      bit            carries;
      bit            eor;
      bit            done;
      logic [OW-1:0] final_off;
   } esc_beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [7:0]    req_text_byte = '0;
   logic          req_first_of_string = 1'b0;
   logic          req_last_of_string = 1'b0;
   logic          req_string_empty = 1'b0;
   logic [OW-1:0] req_start_offset = '0;
   logic [OW-1:0] req_capacity = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [7:0]    rsp_out_byte;
   logic [OW-1:0] rsp_write_offset;
   logic          rsp_carries_byte;
   logic          rsp_end_of_run;
   logic          rsp_string_done;
   logic [OW-1:0] rsp_final_offset;

   src_item_type source_items[$];
   src_item_type on_wire;
   esc_beat_type escaped_beats[$];
   int          errors = 0;
   int          n_accepted = 0;
   int          total_items = 1;

   // escaper state
   logic [7:0]  seq_bytes [3];
   int unsigned seq_count = 0;
   int unsigned seq_want = 0;
   int unsigned wr_off = 0;
   int unsigned budget = 0;
   bit          stopped = 1'b0;

   json_string_escaper_utf8_budget dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .req_string_empty    (req_string_empty),
      .req_start_offset    (req_start_offset),
      .req_capacity        (req_capacity),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_write_offset    (rsp_write_offset),
      .rsp_carries_byte    (rsp_carries_byte),
      .rsp_end_of_run      (rsp_end_of_run),
      .rsp_string_done     (rsp_string_done),
      .rsp_final_offset    (rsp_final_offset)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + nib : 8'h57 + nib;
   endfunction

   function automatic int unsigned lead_len(logic [7:0] c);
      if (c >= 8'hc2 && c <= 8'hdf) return 2;
      if (c >= 8'he0 && c <= 8'hef) return 3;
      if (c >= 8'hf0 && c <= 8'hf4) return 4;
      return 1;
   endfunction

   // whole unit or nothing; first miss stops the string
   function automatic void write_unit(logic [5:0][7:0] u, int unsigned n);
      if (stopped) return;
      if (wr_off + n > budget) begin
         stopped = 1'b1;
         return;
      end
      for (int i = 0; i < n; i++) begin
         escaped_beats.push_back('{u[i], wr_off[OW-1:0], 1'b1, 1'b0, 1'b0, '0});
         wr_off = (wr_off + 1) & OFF_MASK;
      end
   endfunction

   function automatic void escape_fresh(logic [7:0] c);
      logic [5:0][7:0] u;
      int unsigned     n;
      u = '0;
      n = 2;
      if (lead_len(c) > 1) begin
         seq_bytes[0] = c;
         seq_count = 1;
         seq_want = lead_len(c);
         return;
      end
      u[0] = CH_BSLASH;
      case (c)
         CH_QUOTE:  u[1] = CH_QUOTE;
         CH_BSLASH: u[1] = CH_BSLASH;
         CH_LF:     u[1] = "n";
         CH_CR:     u[1] = "r";
         CH_TAB:    u[1] = "t";
         CH_BS:     u[1] = "b";
         CH_FF:     u[1] = "f";
         default: begin
            if (c < CH_SPACE) begin
               u[1] = "u";
               u[2] = "0";
               u[3] = "0";
               u[4] = hex_char(c[7:4]);
               u[5] = hex_char(c[3:0]);
               n = 6;
            end else begin
               u[0] = c;
               n = 1;
            end
         end
      endcase
      write_unit(u, n);
   endfunction

   function automatic void flush_seq();
      for (int i = 0; i < seq_count && i < 3; i++) write_unit({40'd0, seq_bytes[i]}, 1);
      seq_count = 0;
      seq_want = 0;
   endfunction

   function automatic void take_byte(logic [7:0] c);
      logic [5:0][7:0] u;
      u = '0;
      if (seq_count == 0) begin
         escape_fresh(c);
      end else if (c[7:6] != 2'b10) begin
         flush_seq();
         escape_fresh(c);
      end else if (seq_count + 1 >= seq_want || seq_count >= 3) begin
         for (int i = 0; i < seq_count; i++) u[i] = seq_bytes[i];
         u[seq_count] = c;
         write_unit(u, seq_count + 1);
         seq_count = 0;
         seq_want = 0;
      end else begin
         seq_bytes[seq_count] = c;
         seq_count++;
      end
   endfunction

   function automatic void escape_item(src_item_type it);
      int unsigned queued;
      queued = escaped_beats.size();
      if (it.first) begin
         wr_off = 32'(it.start);
         budget = 32'(it.cap);
         stopped = 1'b0;
         seq_count = 0;
         seq_want = 0;
      end
      if (!it.empty) take_byte(it.text);
      if (it.last) begin
         flush_seq();
         escaped_beats.push_back('{8'h00, wr_off[OW-1:0], 1'b0, 1'b0, 1'b1, wr_off[OW-1:0]});
      end
      if (escaped_beats.size() > queued) escaped_beats[escaped_beats.size() - 1].eor = 1'b1;
   endfunction

   function automatic void add_item(logic [7:0] text, bit first, bit last, bit empty,
                                    logic [OW-1:0] start, logic [OW-1:0] cap, bit hold);
      source_items.push_back('{text, first, last, empty, start, cap, hold});
   endfunction

   function automatic int idle_pct(bit sender);
      int third;
      third = n_accepted * 3 / total_items;
      if (third == 0) return sender ? 11 : 71;
      if (third == 1) return sender ? 71 : 11;
      return 0;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            escape_item(on_wire);
            n_accepted++;
         end
         if (source_items.size() != 0 && !(source_items[0].hold && escaped_beats.size() != 0)
             && $urandom_range(99, 0) >= idle_pct(1'b1)) begin
            on_wire = source_items.pop_front();
            req_valid           <= 1'b1;
            req_text_byte       <= on_wire.text;
            req_first_of_string <= on_wire.first;
            req_last_of_string  <= on_wire.last;
            req_string_empty    <= on_wire.empty;
            req_start_offset    <= on_wire.start;
            req_capacity        <= on_wire.cap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      esc_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (escaped_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none actual byte %h offset %h done %b",
                        $time, rsp_out_byte, rsp_write_offset, rsp_string_done);
               errors++;
            end else begin
               want = escaped_beats.pop_front();
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("write_offset", want.write_offset, rsp_write_offset);
               compare_field("carries_byte", want.carries, rsp_carries_byte);
               compare_field("end_of_run", want.eor, rsp_end_of_run);
               compare_field("string_done", want.done, rsp_string_done);
               compare_field("final_offset", want.final_off, rsp_final_offset);
            end
         end
         rsp_ready <= $urandom_range(99, 0) >= idle_pct(1'b0);
      end
   end

   initial begin
      logic [8:0]    body[$];
      logic [OW-1:0] s;
      logic [OW-1:0] c;
      int            rand_items;
      int            kind;
      int            len;
      int            span;
      bit            with_first;
      bit            with_last;
      bit            hold;

      // directed: empty string at zero budget, escapes, UTF-8, budget stop, orphans
      add_item(8'h41, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0);
      for (int i = 0; i < 12; i++)
         add_item(ESC_SET[i], i == 0, i == 11, 1'b0, 16'h0000, 16'hffff, 1'b0);
      for (int i = 0; i < 10; i++)
         add_item(UTF_SET[i], i == 0, i == 9, 1'b0, 16'hfff0, 16'hffff, 1'b0);
      add_item(8'h7a, 1'b0, 1'b0, 1'b0, 16'h1234, 16'h1234, 1'b0);
      add_item(8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0);
      add_item(8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0);
      add_item(8'h01, 1'b1, 1'b0, 1'b0, 16'hffff, 16'hffff, 1'b0);
      add_item(8'h61, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0);

      rand_items = 0;
      hold = 1'b1;
      while (rand_items < 182) begin
         body.delete();
         if ($urandom_range(19, 0) == 0) begin
            body.push_back({1'b1, 8'($urandom_range(255, 0))});
         end else begin
            for (int u = $urandom_range(5, 1); u > 0; u--) begin
               kind = $urandom_range(99, 0);
               if (kind < 20) begin
                  body.push_back({1'b0, 8'($urandom_range(8'h7e, 8'h20))});
               end else if (kind < 32) begin
                  case ($urandom_range(6, 0))
                     0: body.push_back({1'b0, CH_QUOTE});
                     1: body.push_back({1'b0, CH_BSLASH});
                     2: body.push_back({1'b0, CH_LF});
                     3: body.push_back({1'b0, CH_CR});
                     4: body.push_back({1'b0, CH_TAB});
                     5: body.push_back({1'b0, CH_BS});
                     default: body.push_back({1'b0, CH_FF});
                  endcase
               end else if (kind < 42) begin
                  body.push_back({1'b0, 8'($urandom_range(31, 0))});
               end else if (kind < 82) begin
                  len = $urandom_range(4, 2);
                  case (len)
                     2: body.push_back({1'b0, 8'($urandom_range(8'hdf, 8'hc2))});
                     3: body.push_back({1'b0, 8'($urandom_range(8'hef, 8'he0))});
                     default: body.push_back({1'b0, 8'($urandom_range(8'hf4, 8'hf0))});
                  endcase
                  // short continuation run leaves a broken sequence
                  span = (kind < 72) ? len - 1 : $urandom_range(len - 2, 0);
                  for (int k = 0; k < span; k++)
                     body.push_back({1'b0, 8'($urandom_range(8'hbf, 8'h80))});
               end else if (kind < 90) begin
                  case ($urandom_range(2, 0))
                     0: body.push_back({1'b0, 8'($urandom_range(8'hbf, 8'h80))});
                     1: body.push_back({1'b0, 8'($urandom_range(8'hc1, 8'hc0))});
                     default: body.push_back({1'b0, 8'($urandom_range(8'hff, 8'hf5))});
                  endcase
               end else if (kind < 95) begin
                  body.push_back({1'b1, 8'($urandom_range(255, 0))});
               end else begin
                  body.push_back({1'b0, 8'($urandom_range(255, 0))});
               end
            end
         end
         case ($urandom_range(9, 0))
            0: begin
               s = 16'($urandom_range(65535, 0));
               c = 16'($urandom_range(65535, 0));
            end
            1: begin
               s = 16'(16'hffff - $urandom_range(12, 0));
               c = 16'hffff;
            end
            2: begin
               s = 16'($urandom_range(65535, 1));
               c = 16'($urandom_range(s - 1, 0));
            end
            default: begin
               s = 16'($urandom_range(65535, 0));
               c = (int'(s) + $urandom_range(30, 0) > 65535) ? 16'hffff
                                                             : 16'(s + $urandom_range(30, 0));
            end
         endcase
         with_first = $urandom_range(19, 0) != 0;
         with_last = $urandom_range(9, 0) != 0;
         for (int i = 0; i < body.size(); i++) begin
            if (i == 0)
               add_item(body[i][7:0], with_first, with_last && body.size() == 1,
                        body[i][8], s, c, hold);
            else
               add_item(body[i][7:0], 1'b0, with_last && i == body.size() - 1, body[i][8],
                        16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)), 1'b0);
         end
         rand_items += body.size();
         hold = $urandom_range(29, 0) == 0;
      end
      total_items = source_items.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (source_items.size() != 0 || req_valid || escaped_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
